@@ src/bid_pkg.sv @@
// ----------------------------------------------------------------------------
// bid_pkg
// Shared widths, command and status codes, and the controller-to-datapath
// command bundle of the bounded indexed deque.
// ----------------------------------------------------------------------------
`default_nettype none

package bid_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
    } bid_cmd_t;

endpackage

`default_nettype wire

@@ src/bid_ctrl.sv @@
// ----------------------------------------------------------------------------
// bid_ctrl
// Controller: takes one request, steps the datapath through execute and
// capture, then holds the response until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bid_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output bid_pkg::bid_cmd_t  dp_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CAPTURE,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   stall_reg;
    logic   valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_EXEC;
                        stall_reg <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_CAPTURE;
                end
                S_CAPTURE:
                begin
                    state_reg <= S_OUT;
                    valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (!rsp_stall)
                    begin
                        state_reg <= S_IDLE;
                        valid_reg <= 1'b0;
                        stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    valid_reg <= 1'b0;
                    stall_reg <= 1'b0;
                end
            endcase
        end
    end

    assign req_stall      = stall_reg;
    assign rsp_valid      = valid_reg;
    assign dp_cmd.load    = req_valid && !stall_reg;
    assign dp_cmd.exec    = (state_reg == S_EXEC);
    assign dp_cmd.capture = (state_reg == S_CAPTURE);

endmodule

`default_nettype wire

@@ src/bid_dp.sv @@
// ----------------------------------------------------------------------------
// bid_dp
// Datapath: request registers, ring pointer and fill count, element store
// with registered read, and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bid_dp #(
    parameter int CAPACITY = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire bid_pkg::bid_cmd_t                    dp_cmd,
    input  wire logic [bid_pkg::CMD_W-1:0]            cmd,
    input  wire logic [bid_pkg::POS_W-1:0]            position,
    input  wire logic signed [bid_pkg::VALUE_W-1:0]   value,
    output logic [bid_pkg::STATUS_W-1:0]              status,
    output logic signed [bid_pkg::VALUE_W-1:0]        read_value,
    output logic [$clog2(CAPACITY+1)-1:0]             count,
    output logic                                      is_empty
);

    localparam int PTR_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam int CMP_W = (CNT_W > bid_pkg::POS_W) ? CNT_W : bid_pkg::POS_W;

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);
    localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

    logic [bid_pkg::CMD_W-1:0]      cmd_reg;
    logic [bid_pkg::POS_W-1:0]      pos_reg;
    logic [bid_pkg::VALUE_W-1:0]    value_reg;

    logic [PTR_W-1:0]               front_reg;
    logic [PTR_W-1:0]               front_next;
    logic [CNT_W-1:0]               fill_reg;
    logic [CNT_W-1:0]               fill_next;

    logic [bid_pkg::VALUE_W-1:0]    mem [CAPACITY];
    logic [bid_pkg::VALUE_W-1:0]    mem_q;
    logic [PTR_W-1:0]               mem_addr;
    logic                           mem_we;
    logic                           mem_re;

    logic [bid_pkg::STATUS_W-1:0]   op_status;
    logic [bid_pkg::STATUS_W-1:0]   op_status_reg;
    logic                           op_read_reg;

    logic [bid_pkg::STATUS_W-1:0]   status_reg;
    logic [bid_pkg::VALUE_W-1:0]    read_value_reg;
    logic [CNT_W-1:0]               count_reg;
    logic                           is_empty_reg;

    logic                           is_full;
    logic                           no_elems;
    logic                           pos_bad;
    logic [PTR_W-1:0]               front_inc;
    logic [PTR_W-1:0]               front_dec;
    logic [PTR_W-1:0]               back_slot;
    logic [PTR_W-1:0]               pos_slot;

    function automatic logic [PTR_W-1:0] ring_wrap(input logic [PTR_W-1:0] base,
                                                   input logic [SUM_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        begin
            sum = {1'b0, base} + offset;
            if (sum >= CAP_SUM)
            begin
                sum = sum - CAP_SUM;
            end
            ring_wrap = sum[PTR_W-1:0];
        end
    endfunction

    assign is_full   = (fill_reg == CAP_CNT);
    assign no_elems  = (fill_reg == '0);
    assign pos_bad   = (CMP_W'(pos_reg) >= CMP_W'(fill_reg));
    assign front_inc = (front_reg == LAST_PTR) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_PTR : front_reg - 1'b1;
    assign back_slot = ring_wrap(front_reg, SUM_W'(fill_reg));
    assign pos_slot  = ring_wrap(front_reg, SUM_W'(pos_reg));

    always_comb
    begin
        front_next = front_reg;
        fill_next  = fill_reg;
        op_status  = bid_pkg::ST_OK;
        mem_addr   = pos_slot;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        case (cmd_reg)
            bid_pkg::CMD_PUSH_BACK:
            begin
                if (is_full)
                begin
                    op_status = bid_pkg::ST_FULL;
                end
                else
                begin
                    mem_addr  = back_slot;
                    mem_we    = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
            bid_pkg::CMD_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    op_status = bid_pkg::ST_FULL;
                end
                else
                begin
                    front_next = front_dec;
                    mem_addr   = front_dec;
                    mem_we     = 1'b1;
                    fill_next  = fill_reg + 1'b1;
                end
            end
            bid_pkg::CMD_POP_BACK:
            begin
                if (no_elems)
                begin
                    op_status = bid_pkg::ST_EMPTY;
                end
                else
                begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            bid_pkg::CMD_POP_FRONT:
            begin
                if (no_elems)
                begin
                    op_status = bid_pkg::ST_EMPTY;
                end
                else
                begin
                    front_next = front_inc;
                    fill_next  = fill_reg - 1'b1;
                end
            end
            bid_pkg::CMD_READ:
            begin
                if (pos_bad)
                begin
                    op_status = bid_pkg::ST_RANGE;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            bid_pkg::CMD_WRITE:
            begin
                if (pos_bad)
                begin
                    op_status = bid_pkg::ST_RANGE;
                end
                else
                begin
                    mem_we = 1'b1;
                end
            end
            default:
            begin
                op_status = bid_pkg::ST_OK;
            end
        endcase
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg   <= cmd;
            pos_reg   <= position;
            value_reg <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            fill_reg  <= '0;
        end
        else if (dp_cmd.exec)
        begin
            front_reg <= front_next;
            fill_reg  <= fill_next;
        end
    end

    // element store
    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec && mem_we)
        begin
            mem[mem_addr] <= value_reg;
        end
        if (dp_cmd.exec && mem_re)
        begin
            mem_q <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec)
        begin
            op_status_reg <= op_status;
            op_read_reg   <= mem_re;
        end
        if (dp_cmd.capture)
        begin
            status_reg     <= op_status_reg;
            read_value_reg <= op_read_reg ? mem_q : '0;
            count_reg      <= fill_reg;
            is_empty_reg   <= no_elems;
        end
    end

    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign count      = count_reg;
    assign is_empty   = is_empty_reg;

endmodule

`default_nettype wire

@@ src/bounded_indexed_deque.sv @@
// ----------------------------------------------------------------------------
// bounded_indexed_deque
// Bounded double-ended queue of signed words held in a ring, with push and
// pop at both ends and read or write by position from the front.
//
//   channel    handshake             payload
//   request    req_valid/req_stall   cmd, position, value
//   response   rsp_valid/rsp_stall   status, read_value, count, is_empty
//
// each request passes through accept, execute on the ring and store,
// capture of the registered store read, and response held; the single-port
// store with registered read calls for the separate capture step.
// one request in flight; req_stall stays high until its response is taken.
// reset clears the controller state, pointer and count only; store contents are undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_indexed_deque #(
    parameter int CAPACITY = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 req_valid,
    output logic                                      req_stall,
    input  wire logic [bid_pkg::CMD_W-1:0]            cmd,
    input  wire logic [bid_pkg::POS_W-1:0]            position,
    input  wire logic signed [bid_pkg::VALUE_W-1:0]   value,
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_stall,
    output logic [bid_pkg::STATUS_W-1:0]              status,
    output logic signed [bid_pkg::VALUE_W-1:0]        read_value,
    output logic [$clog2(CAPACITY+1)-1:0]             count,
    output logic                                      is_empty
);

    bid_pkg::bid_cmd_t dp_cmd;

    bid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .dp_cmd    (dp_cmd)
    );

    bid_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .cmd        (cmd),
        .position   (position),
        .value      (value),
        .status     (status),
        .read_value (read_value),
        .count      (count),
        .is_empty   (is_empty)
    );

    a_single_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("request taken while response pending");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (req_stall && !rsp_valid))
        else $error("controller did not lock after request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (count <= ($clog2(CAPACITY+1))'(CAPACITY)))
        else $error("count beyond capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (count == '0)))
        else $error("empty flag disagrees with count");

endmodule

`default_nettype wire
